// ===== sv/cppr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants, cosine table and command/status structs.
package cppr_pkg;

	localparam int FRAME_MAX_DEF = 1024;
	localparam int SAMPLE_WIDTH  = 16;
	localparam int STORE_W       = 24;
	localparam int CFG_W         = 32;
	localparam int CFG_IDX_W     = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_PER_HZ  = 1'd1;

	localparam logic [10:0] FRAME_LENGTH_RST = 11'd512;
	localparam logic [31:0] STEP_PER_HZ_RST  = 32'd89478;

	localparam logic [15:0] QUARTER_COS [0:64] = '{
		16'd32768, 16'd32758, 16'd32729, 16'd32679, 16'd32610, 16'd32522, 16'd32413, 16'd32286,
		16'd32138, 16'd31972, 16'd31786, 16'd31581, 16'd31356, 16'd31114, 16'd30853, 16'd30572,
		16'd30274, 16'd29957, 16'd29622, 16'd29269, 16'd28899, 16'd28511, 16'd28106, 16'd27684,
		16'd27246, 16'd26791, 16'd26319, 16'd25833, 16'd25330, 16'd24812, 16'd24279, 16'd23732,
		16'd23170, 16'd22595, 16'd22006, 16'd21403, 16'd20788, 16'd20160, 16'd19520, 16'd18868,
		16'd18205, 16'd17531, 16'd16846, 16'd16151, 16'd15447, 16'd14733, 16'd14010, 16'd13279,
		16'd12540, 16'd11793, 16'd11039, 16'd10279, 16'd9512,  16'd8740,  16'd7962,  16'd7180,
		16'd6393,  16'd5602,  16'd4808,  16'd4011,  16'd3212,  16'd2411,  16'd1608,  16'd804,
		16'd0
	};

	typedef struct packed {
		logic                           kind;
		logic [15:0]                    amp_start;
		logic [15:0]                    amp_end;
		logic [19:0]                    freq_start;
		logic [19:0]                    freq_end;
		logic signed [15:0]             phase_start;
		logic signed [15:0]             phase_end;
		logic signed [SAMPLE_WIDTH-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] residual;
		logic signed [SAMPLE_WIDTH-1:0] synthesis;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLR, OP_W1, OP_W2, OP_WN, OP_FIX, OP_X2A, OP_X2B, OP_E2,
		OP_DVD_GO, OP_DVA_GO, OP_SD_STEP, OP_DVD_END, OP_DVA_END,
		OP_K_INIT, OP_K_MUL1, OP_K_MUL2, OP_K_MUL3, OP_K_DIV, OP_K_PROD,
		OP_K_SUM, OP_K_COS, OP_K_AMP, OP_K_WR, OP_S_RD, OP_S_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DEC, S_W1, S_W2, S_WN, S_FIX, S_X2A, S_X2B, S_E2,
		S_DVD_GO, S_DVD_RUN, S_DVD_END, S_DVA_GO, S_DVA_RUN, S_DVA_END,
		S_K_INIT, S_K_MUL1, S_K_MUL2, S_K_MUL3, S_K_DIV, S_K_PROD,
		S_K_SUM, S_K_COS, S_K_AMP, S_K_WR, S_S_RD, S_S_OUT
	} state_t;

	typedef struct packed {
		logic   load;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic kind;
		logic skip;
		logic sd_last;
		logic kd_last;
		logic k_last;
		logic clr_last;
		logic slot_free;
	} dp_stat_t;

	// quarter wave, 8 bits of linear interpolation
	function automatic logic signed [16:0] quarter(input logic [14:0] pos);
		logic [6:0]  i;
		logic [7:0]  f;
		logic [15:0] a;
		logic [15:0] b;
		logic [17:0] m;
		i = pos[14:8];
		f = pos[7:0];
		if (i >= 7'd64) begin
			return 17'sd0;
		end
		a = QUARTER_COS[i];
		b = QUARTER_COS[i + 7'd1];
		m = 18'(a - b) * 18'(f);
		return $signed(17'(a) - 17'(m[17:8]));
	endfunction

	function automatic logic signed [16:0] cos_turn(input logic [31:0] ph);
		logic [14:0] pos;
		pos = {1'b0, ph[29:16]};
		case (ph[31:30])
			2'd0: return quarter(pos);
			2'd1: return -quarter(15'd16384 - pos);
			2'd2: return -quarter(pos);
			default: return quarter(15'd16384 - pos);
		endcase
	endfunction

endpackage

// ===== sv/cppr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences the clearing pass, setup, per-position synthesis and sample output.
module cppr_ctrl import cppr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_DEC;
			end
			S_DEC: begin
				if (stat.kind) state_d = S_S_RD;
				else if (stat.skip) state_d = S_IDLE;
				else state_d = S_W1;
			end
			S_W1:      state_d = S_W2;
			S_W2:      state_d = S_WN;
			S_WN:      state_d = S_FIX;
			S_FIX:     state_d = S_X2A;
			S_X2A:     state_d = S_X2B;
			S_X2B:     state_d = S_E2;
			S_E2:      state_d = S_DVD_GO;
			S_DVD_GO:  state_d = S_DVD_RUN;
			S_DVD_RUN: begin
				if (stat.sd_last) state_d = S_DVD_END;
			end
			S_DVD_END: state_d = S_DVA_GO;
			S_DVA_GO:  state_d = S_DVA_RUN;
			S_DVA_RUN: begin
				if (stat.sd_last) state_d = S_DVA_END;
			end
			S_DVA_END: state_d = S_K_INIT;
			S_K_INIT:  state_d = S_K_MUL1;
			S_K_MUL1:  state_d = S_K_MUL2;
			S_K_MUL2:  state_d = S_K_MUL3;
			S_K_MUL3:  state_d = S_K_DIV;
			S_K_DIV: begin
				if (stat.kd_last) state_d = S_K_PROD;
			end
			S_K_PROD:  state_d = S_K_SUM;
			S_K_SUM:   state_d = S_K_COS;
			S_K_COS:   state_d = S_K_AMP;
			S_K_AMP:   state_d = S_K_WR;
			S_K_WR: begin
				if (stat.k_last) state_d = S_IDLE;
				else state_d = S_K_MUL1;
			end
			S_S_RD:    state_d = S_S_OUT;
			S_S_OUT: begin
				if (stat.slot_free) state_d = S_IDLE;
			end
			default:   state_d = S_CLR;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd.load = in_ready && in_valid;
		case (state_q)
			S_CLR:     cmd.op = OP_CLR;
			S_W1:      cmd.op = OP_W1;
			S_W2:      cmd.op = OP_W2;
			S_WN:      cmd.op = OP_WN;
			S_FIX:     cmd.op = OP_FIX;
			S_X2A:     cmd.op = OP_X2A;
			S_X2B:     cmd.op = OP_X2B;
			S_E2:      cmd.op = OP_E2;
			S_DVD_GO:  cmd.op = OP_DVD_GO;
			S_DVD_RUN: cmd.op = OP_SD_STEP;
			S_DVD_END: cmd.op = OP_DVD_END;
			S_DVA_GO:  cmd.op = OP_DVA_GO;
			S_DVA_RUN: cmd.op = OP_SD_STEP;
			S_DVA_END: cmd.op = OP_DVA_END;
			S_K_INIT:  cmd.op = OP_K_INIT;
			S_K_MUL1:  cmd.op = OP_K_MUL1;
			S_K_MUL2:  cmd.op = OP_K_MUL2;
			S_K_MUL3:  cmd.op = OP_K_MUL3;
			S_K_DIV:   cmd.op = OP_K_DIV;
			S_K_PROD:  cmd.op = OP_K_PROD;
			S_K_SUM:   cmd.op = OP_K_SUM;
			S_K_COS:   cmd.op = OP_K_COS;
			S_K_AMP:   cmd.op = OP_K_AMP;
			S_K_WR:    cmd.op = OP_K_WR;
			S_S_RD:    cmd.op = OP_S_RD;
			S_S_OUT:   cmd.op = stat.slot_free ? OP_S_OUT : OP_NONE;
			default:   cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== sv/cppr_dp.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, segment setup, per-position phase/amplitude, frame store.
module cppr_dp import cppr_pkg::*; #(
	parameter int FRAME_MAX = FRAME_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  in_item_t             in_item,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item
);

	localparam int NW   = $clog2(FRAME_MAX + 1);
	localparam int KW   = $clog2(FRAME_MAX);
	localparam int K2W  = 2 * KW;
	localparam int N3W  = 3 * NW;
	localparam int AW   = N3W + 2;
	localparam int SIT  = 20;
	localparam int KIT  = (K2W > SIT) ? K2W : SIT;
	localparam int IW   = $clog2(KIT + 1);
	localparam int SDN  = 33;
	localparam int SDW  = 6;
	localparam int SH   = 32 - SAMPLE_WIDTH;
	localparam int CW   = 34 - SH;

	localparam logic signed [STORE_W:0] ST_HI  = (STORE_W+1)'((1 << (STORE_W - 1)) - 1);
	localparam logic signed [STORE_W:0] ST_LO  = (STORE_W+1)'(-(1 << (STORE_W - 1)));
	localparam logic signed [STORE_W:0] SMP_HI = (STORE_W+1)'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [STORE_W:0] SMP_LO = (STORE_W+1)'(-(1 << (SAMPLE_WIDTH - 1)));

	function automatic logic [31:0] step_of(input logic [19:0] f, input logic [31:0] s);
		logic [51:0] p;
		p = 52'(f) * 52'(s);
		return p[35:4];
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_smp(input logic signed [STORE_W:0] v);
		if (v > SMP_HI) return SAMPLE_WIDTH'(SMP_HI);
		if (v < SMP_LO) return SAMPLE_WIDTH'(SMP_LO);
		return SAMPLE_WIDTH'(v);
	endfunction

	// configuration
	logic [10:0] fl_q;
	logic [31:0] sph_q;
	logic [NW-1:0] n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_q  <= FRAME_LENGTH_RST;
			sph_q <= STEP_PER_HZ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_LENGTH: fl_q  <= cfg_data[10:0];
				REG_STEP_PER_HZ:  sph_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fl_q == 11'd0) n_eff = NW'(1);
		else if (32'(fl_q) > 32'(FRAME_MAX)) n_eff = NW'(FRAME_MAX);
		else n_eff = NW'(fl_q);
	end

	// item and segment setup
	in_item_t item_q;
	logic [31:0] w1_q, w2_q, wn_q, p1_q, p2_q, w1n_q;
	logic signed [33:0] d_q, e2_q;
	logic [32:0] dn_q;
	logic [2*NW-1:0] n2_q;
	logic [N3W-1:0] n3_q;
	logic [31:0] qd_q;
	logic [NW:0] rd_q;
	logic signed [17:0] qa_q;
	logic [NW-1:0] ra_q;

	// setup divider
	logic [32:0] sd_num_q;
	logic [NW:0] sd_rem_q, sd_den_q;
	logic sd_neg_q;
	logic [SDW-1:0] sd_cnt_q;
	logic [NW+1:0] sd_sh;

	// per-position
	logic [KW-1:0] k_q, rp_q, clr_q;
	logic [K2W-1:0] k2_q;
	logic [3*KW-1:0] k3_q;
	logic [K2W+NW-1:0] k2n_q;
	logic [31:0] w1k_q, qk2_q;
	logic [N3W:0] rs_q;
	logic [SIT-1:0] sq_q;
	logic [NW:0] rdv_q;
	logic [K2W-1:0] xl_q, dq_q;
	logic [IW-1:0] it_q;
	logic signed [37:0] ph_q;
	logic [36:0] pl_q;
	logic [31:0] theta_q;
	logic signed [16:0] cos_q;
	logic signed [CW-1:0] c_q;
	logic signed [17:0] qacc_q;
	logic [NW-1:0] racc_q;

	// store
	logic [STORE_W-1:0] mem [FRAME_MAX];
	logic [STORE_W-1:0] mem_rd_q;
	logic mem_we, mem_re;
	logic [KW-1:0] mem_wa, mem_ra;
	logic [STORE_W-1:0] mem_wd;

	out_item_t out_q;
	logic out_valid_q;

	// combinational helpers
	logic [32:0] x2, r_e2, d_abs, da_abs;
	logic signed [16:0] da;
	logic [AW-1:0] a_full;
	logic [NW+K2W:0] rk2;
	logic [N3W:0] rs2;
	logic [NW+1:0] rdv2;
	logic [54:0] e2s;
	logic [15:0] amp;
	logic signed [33:0] ap;
	logic signed [STORE_W:0] st_sum, smp_diff;
	logic [NW:0] rsum;
	logic slot_free;

	always_comb begin
		x2     = {32'(p1_q + w1n_q - p2_q), 1'b0} + dn_q;
		r_e2   = x2 + 33'h1_0000_0000;
		d_abs  = d_q[33] ? 33'(-d_q) : 33'(d_q);
		da     = $signed({1'b0, item_q.amp_end}) - $signed({1'b0, item_q.amp_start});
		da_abs = da[16] ? 33'(-da) : 33'(da);
		a_full = (AW'(k2n_q) << 1) + AW'(k2n_q) - (AW'(k3_q) << 1);
		rk2    = (NW+K2W+1)'(rd_q) * (NW+K2W+1)'(k2_q);
		sd_sh  = {sd_rem_q, sd_num_q[32]};
		rs2    = {rs_q[N3W-1:0], 1'b0};
		rdv2   = {rdv_q, xl_q[K2W-1]};
		e2s    = {ph_q, 17'b0} + 55'(pl_q);
		amp    = 16'(18'(item_q.amp_start) + qacc_q);
		ap     = $signed({1'b0, amp}) * cos_q;
		st_sum = $signed({mem_rd_q[STORE_W-1], mem_rd_q}) + (STORE_W+1)'(c_q);
		smp_diff = (STORE_W+1)'(item_q.sample) - $signed({mem_rd_q[STORE_W-1], mem_rd_q});
		rsum   = (NW+1)'(racc_q) + (NW+1)'(ra_q);
		slot_free = !out_valid_q || out_ready;
	end

	always_comb begin
		stat.kind      = item_q.kind;
		stat.skip      = (item_q.amp_start == 16'd0) && (item_q.amp_end == 16'd0);
		stat.sd_last   = (sd_cnt_q == SDW'(1));
		stat.kd_last   = (it_q == IW'(KIT - 1));
		stat.k_last    = ((NW+1)'(k_q) + (NW+1)'(1)) >= (NW+1)'(n_eff);
		stat.clr_last  = (clr_q == KW'(FRAME_MAX - 1));
		stat.slot_free = slot_free;
	end

	// store port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = k_q;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = k_q;
		case (cmd.op)
			OP_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			OP_K_PROD: mem_re = 1'b1;
			OP_K_WR: begin
				mem_we = 1'b1;
				if (st_sum > ST_HI) mem_wd = STORE_W'(ST_HI);
				else if (st_sum < ST_LO) mem_wd = STORE_W'(ST_LO);
				else mem_wd = STORE_W'(st_sum);
			end
			OP_S_RD: begin
				mem_re = 1'b1;
				mem_ra = rp_q;
			end
			OP_S_OUT: begin
				mem_we = 1'b1;
				mem_wa = rp_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) mem_rd_q <= mem[mem_ra];
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rp_q        <= '0;
			sd_cnt_q    <= '0;
			it_q        <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLR) clr_q <= clr_q + KW'(1);
			if (cmd.op == OP_DVD_GO || cmd.op == OP_DVA_GO) sd_cnt_q <= SDW'(SDN);
			else if (cmd.op == OP_SD_STEP) sd_cnt_q <= sd_cnt_q - SDW'(1);
			if (cmd.op == OP_K_MUL3) it_q <= '0;
			else if (cmd.op == OP_K_DIV) it_q <= it_q + IW'(1);
			if (cmd.op == OP_K_INIT) k_q <= '0;
			else if (cmd.op == OP_K_WR) k_q <= k_q + KW'(1);
			if (cmd.op == OP_S_OUT) begin
				if (((NW+1)'(rp_q) + (NW+1)'(1)) < (NW+1)'(n_eff)) rp_q <= rp_q + KW'(1);
				else rp_q <= '0;
			end
			if (cmd.op == OP_S_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		case (cmd.op)
			OP_W1: begin
				w1_q <= step_of(item_q.freq_start, sph_q);
				n2_q <= (2*NW)'(n_eff) * (2*NW)'(n_eff);
			end
			OP_W2: begin
				w2_q <= step_of(item_q.freq_end, sph_q);
				n3_q <= N3W'(n2_q) * N3W'(n_eff);
			end
			OP_WN: begin
				wn_q <= ((item_q.amp_start == 16'd0) ? w2_q : w1_q) * 32'(n_eff);
			end
			OP_FIX: begin
				// a silent end takes the other end's frequency and extrapolated phase
				if (item_q.amp_start == 16'd0) begin
					w1_q <= w2_q;
					p1_q <= {item_q.phase_end, 16'h0} - wn_q;
				end else begin
					p1_q <= {item_q.phase_start, 16'h0};
				end
				if (item_q.amp_end == 16'd0) begin
					w2_q <= w1_q;
					p2_q <= {item_q.phase_start, 16'h0} + wn_q;
				end else begin
					p2_q <= {item_q.phase_end, 16'h0};
				end
			end
			OP_X2A: begin
				w1n_q <= w1_q * 32'(n_eff);
				d_q   <= $signed({{2{w2_q[31]}}, w2_q}) - $signed({{2{w1_q[31]}}, w1_q});
			end
			OP_X2B: dn_q <= 33'(34'(d_q) * 34'(n_eff));
			OP_E2: e2_q <= 34'h1_0000_0000 - {1'b0, r_e2};
			OP_DVD_GO: begin
				sd_num_q <= d_abs;
				sd_den_q <= {n_eff, 1'b0};
				sd_rem_q <= '0;
				sd_neg_q <= d_q[33];
			end
			OP_DVA_GO: begin
				sd_num_q <= da_abs;
				sd_den_q <= (NW+1)'(n_eff);
				sd_rem_q <= '0;
				sd_neg_q <= da[16];
			end
			OP_SD_STEP: begin
				if (sd_sh >= {1'b0, sd_den_q}) begin
					sd_rem_q <= (NW+1)'(sd_sh - {1'b0, sd_den_q});
					sd_num_q <= {sd_num_q[31:0], 1'b1};
				end else begin
					sd_rem_q <= (NW+1)'(sd_sh);
					sd_num_q <= {sd_num_q[31:0], 1'b0};
				end
			end
			OP_DVD_END: begin
				// floor for a negative dividend
				if (sd_neg_q && sd_rem_q != '0) begin
					qd_q <= ~sd_num_q[31:0];
					rd_q <= sd_den_q - sd_rem_q;
				end else if (sd_neg_q) begin
					qd_q <= 32'd0 - sd_num_q[31:0];
					rd_q <= '0;
				end else begin
					qd_q <= sd_num_q[31:0];
					rd_q <= sd_rem_q;
				end
			end
			OP_DVA_END: begin
				if (sd_neg_q && sd_rem_q != '0) begin
					qa_q <= ~sd_num_q[17:0];
					ra_q <= NW'(sd_den_q - sd_rem_q);
				end else if (sd_neg_q) begin
					qa_q <= 18'd0 - sd_num_q[17:0];
					ra_q <= '0;
				end else begin
					qa_q <= sd_num_q[17:0];
					ra_q <= NW'(sd_rem_q);
				end
			end
			OP_K_INIT: begin
				qacc_q <= '0;
				racc_q <= '0;
			end
			OP_K_MUL1: begin
				k2_q  <= K2W'(k_q) * K2W'(k_q);
				w1k_q <= w1_q * 32'(k_q);
			end
			OP_K_MUL2: begin
				k3_q  <= (3*KW)'(k2_q) * (3*KW)'(k_q);
				k2n_q <= (K2W+NW)'(k2_q) * (K2W+NW)'(n_eff);
				qk2_q <= qd_q * 32'(k2_q);
			end
			OP_K_MUL3: begin
				// both divisions yield bounded quotients: start from the top remainder
				rs_q  <= (N3W+1)'(a_full);
				rdv_q <= rk2[NW+K2W:K2W];
				xl_q  <= rk2[K2W-1:0];
				sq_q  <= '0;
				dq_q  <= '0;
			end
			OP_K_DIV: begin
				if (it_q < IW'(SIT)) begin
					if (rs2 >= {1'b0, n3_q}) begin
						rs_q <= rs2 - {1'b0, n3_q};
						sq_q <= {sq_q[SIT-2:0], 1'b1};
					end else begin
						rs_q <= rs2;
						sq_q <= {sq_q[SIT-2:0], 1'b0};
					end
				end
				if (it_q < IW'(K2W)) begin
					xl_q <= {xl_q[K2W-2:0], 1'b0};
					if (rdv2 >= {1'b0, n_eff, 1'b0}) begin
						rdv_q <= (NW+1)'(rdv2 - {1'b0, n_eff, 1'b0});
						dq_q  <= {dq_q[K2W-2:0], 1'b1};
					end else begin
						rdv_q <= (NW+1)'(rdv2);
						dq_q  <= {dq_q[K2W-2:0], 1'b0};
					end
				end
			end
			OP_K_PROD: begin
				ph_q <= $signed(e2_q[33:17]) * $signed({1'b0, sq_q});
				pl_q <= 37'(e2_q[16:0]) * 37'(sq_q);
			end
			OP_K_SUM: theta_q <= p1_q + w1k_q + qk2_q + 32'(dq_q) + e2s[52:21];
			OP_K_COS: cos_q <= cos_turn(theta_q);
			OP_K_AMP: c_q <= ap[33:SH];
			OP_K_WR: begin
				if (rsum >= (NW+1)'(n_eff)) begin
					racc_q <= NW'(rsum - (NW+1)'(n_eff));
					qacc_q <= qacc_q + qa_q + 18'sd1;
				end else begin
					racc_q <= NW'(rsum);
					qacc_q <= qacc_q + qa_q;
				end
			end
			OP_S_OUT: begin
				out_q.residual  <= sat_smp(smp_diff);
				out_q.synthesis <= sat_smp($signed({mem_rd_q[STORE_W-1], mem_rd_q}));
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== sv/cubic_phase_partial_residual.sv =====
`timescale 1ns / 1ps
// Sample item: accepted, decoded, store read, result registered once the output is free.
// Segment item: setup with two 33-step serial divides, then a loop over the N positions,
// each set by a per-position long division of KIT steps, KIT = 20 at FRAME_MAX 1024.
// One item in work at a time; a waiting result does not block a following segment.
// Reset: registers to defaults, then a pass clearing all FRAME_MAX entries, input held off.
module cubic_phase_partial_residual import cppr_pkg::*; #(
	parameter int FRAME_MAX = FRAME_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cppr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cppr_dp #(
		.FRAME_MAX (FRAME_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
